// File: sv/lz78_byte_compressor_defines.svh
// Assertion macros shared by the checker.
`ifndef LZ78_BYTE_COMPRESSOR_DEFINES_SVH
`define LZ78_BYTE_COMPRESSOR_DEFINES_SVH

// Implication in the same cycle, ignored while reset is low.
`define LZ78C_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lz78 check failed");

// Implication in the next cycle, ignored while reset is low.
`define LZ78C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lz78 check failed");

// In the next cycle, also checked across reset.
`define LZ78C_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lz78 reset check failed");

`endif

// File: sv/lz78c_pkg.sv
package lz78c_pkg;

  localparam int DICT_SIZE  = 4096;
  localparam int CODE_SPACE = 4096;
  localparam int CODE_W     = 12;
  localparam int SYM_W      = 8;
  localparam int LIMIT_W    = 13;

  // codes that can ever be handed out
  localparam int CODE_CAP   = (DICT_SIZE < CODE_SPACE) ? DICT_SIZE : CODE_SPACE;
  localparam int ENTRY_AW   = $clog2(CODE_CAP);
  // hash table has twice as many slots as codes, so a probe always ends
  localparam int HASH_W     = ENTRY_AW + 1;
  localparam int HASH_DEPTH = 2 * CODE_CAP;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
  localparam logic [LIMIT_W-1:0] CODE_CAP_L  = LIMIT_W'(CODE_CAP);
  localparam logic [LIMIT_W-1:0] FIRST_CODE  = LIMIT_W'(1);

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_ENTRY,
    ST_EMIT
  } lz78c_state_t;

  typedef struct packed {
    logic [CODE_W-1:0] parent;
    logic [SYM_W-1:0]  symbol;
    logic [HASH_W-1:0] slot;
  } lz78c_entry_t;

  localparam int ENTRY_W = $bits(lz78c_entry_t);

  // xor fold of {node, byte} into a slot number
  function automatic logic [HASH_W-1:0] lz78c_hash(input logic [CODE_W-1:0] node,
                                                   input logic [SYM_W-1:0] sym);
    logic [CODE_W+SYM_W-1:0] key;
    logic [HASH_W-1:0]       h;
    key = {node, sym};
    h   = '0;
    for (int i = 0; i < CODE_W + SYM_W; i++) begin
      h[i % HASH_W] = h[i % HASH_W] ^ key[i];
    end
    return h;
  endfunction

endpackage

// File: sv/lz78c_in_if.sv
interface lz78c_in_if;
  import lz78c_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [SYM_W-1:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// File: sv/lz78c_out_if.sv
interface lz78c_out_if;
  import lz78c_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_index;
  logic [SYM_W-1:0]  code_symbol;
  logic              has_symbol;
  logic              stream_end;

  modport source (output valid, output code_index, output code_symbol,
                  output has_symbol, output stream_end, input ready);
  modport sink   (input valid, input code_index, input code_symbol,
                  input has_symbol, input stream_end, output ready);
endinterface

// File: sv/lz78c_ram.sv
module lz78c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lz78_byte_compressor.sv
// Timing: a byte that ends a phrase passes the hash-slot read (ST_SLOT), the dictionary-entry
//   read when the slot holds a live code (ST_ENTRY) and ST_EMIT, which registers the token;
//   each occupied slot passed adds another ST_SLOT and ST_ENTRY. A finish goes straight to
//   ST_EMIT, which waits while the output stalls. A new item is taken only back in ST_IDLE.
// Reset (synchronous): idle at the root, next code 1, limit 4096; memories are not
//   cleared, and finish empties the dictionary by restarting the codes.
module lz78_byte_compressor (
  input  logic                          clk,
  input  logic                          rst_n,
  lz78c_in_if.sink                      in_ch,
  lz78c_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [lz78c_pkg::LIMIT_W-1:0] cfg_wdata
);
  import lz78c_pkg::*;

  lz78c_state_t       state_r, state_nxt;
  logic [CODE_W-1:0]  cur_r, cur_nxt;
  logic [LIMIT_W-1:0] next_code_r, next_code_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [SYM_W-1:0]   byte_r, byte_nxt;
  logic               fin_r, fin_nxt;
  logic [HASH_W-1:0]  slot_r, slot_nxt;
  logic [CODE_W-1:0]  child_r, child_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]  out_index_r, out_index_nxt;
  logic [SYM_W-1:0]   out_symbol_r, out_symbol_nxt;
  logic               out_has_r, out_has_nxt;
  logic               out_end_r, out_end_nxt;

  // hash table: slot -> code
  logic                hash_we;
  logic [HASH_W-1:0]   hash_raddr;
  logic [CODE_W-1:0]   hash_rdata;
  // dictionary: code -> {parent, byte, owning slot}
  logic                entry_we;
  logic [ENTRY_AW-1:0] entry_raddr;
  lz78c_entry_t        entry_wdata, entry_rdata;

  logic [LIMIT_W-1:0]  code_cap;
  logic                slot_empty;
  logic                out_free;

  lz78c_ram #(.WIDTH(CODE_W), .DEPTH(HASH_DEPTH)) u_hash_ram (
    .clk   (clk),
    .we    (hash_we),
    .waddr (slot_r),
    .wdata (next_code_r[CODE_W-1:0]),
    .raddr (hash_raddr),
    .rdata (hash_rdata)
  );

  lz78c_ram #(.WIDTH(ENTRY_W), .DEPTH(CODE_CAP)) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (next_code_r[ENTRY_AW-1:0]),
    .wdata (entry_wdata),
    .raddr (entry_raddr),
    .rdata (entry_rdata)
  );

  assign code_cap    = (limit_r < CODE_CAP_L) ? limit_r : CODE_CAP_L;
  // a slot is taken only by a live code; ST_ENTRY then checks that it names this slot as its home
  assign slot_empty  = (hash_rdata == '0) || ({1'b0, hash_rdata} >= next_code_r);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign entry_wdata = '{parent: cur_r, symbol: byte_r, slot: slot_r};

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_index  = out_index_r;
  assign out_ch.code_symbol = out_symbol_r;
  assign out_ch.has_symbol  = out_has_r;
  assign out_ch.stream_end  = out_end_r;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    next_code_nxt  = next_code_r;
    byte_nxt       = byte_r;
    fin_nxt        = fin_r;
    slot_nxt       = slot_r;
    child_nxt      = child_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_index_nxt  = out_index_r;
    out_symbol_nxt = out_symbol_r;
    out_has_nxt    = out_has_r;
    out_end_nxt    = out_end_r;
    hash_we        = 1'b0;
    entry_we       = 1'b0;
    hash_raddr     = lz78c_hash(cur_r, in_ch.data_byte);
    entry_raddr    = hash_rdata[ENTRY_AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          byte_nxt  = in_ch.data_byte;
          fin_nxt   = (in_ch.cmd == CMD_FINISH);
          slot_nxt  = hash_raddr;
          state_nxt = (in_ch.cmd == CMD_FINISH) ? ST_EMIT : ST_SLOT;
        end
      end
      ST_SLOT: begin
        child_nxt = hash_rdata;
        if (slot_empty) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_ENTRY;
        end
      end
      ST_ENTRY: begin
        hash_raddr = slot_r + 1'b1;
        if (entry_rdata.slot == slot_r) begin
          if (entry_rdata.parent == cur_r && entry_rdata.symbol == byte_r) begin
            cur_nxt   = child_r;
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt  = hash_raddr;
            state_nxt = ST_SLOT;
          end
        end else begin
          // stale pointer: the slot is free
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = cur_r;
          out_symbol_nxt = fin_r ? '0 : byte_r;
          out_has_nxt    = !fin_r;
          out_end_nxt    = fin_r;
          cur_nxt        = '0;
          state_nxt      = ST_IDLE;
          if (fin_r) begin
            next_code_nxt = FIRST_CODE;
          end else if (next_code_r < code_cap) begin
            hash_we       = 1'b1;
            entry_we      = 1'b1;
            next_code_nxt = next_code_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      next_code_r <= FIRST_CODE;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      next_code_r <= next_code_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    fin_r        <= fin_nxt;
    slot_r       <= slot_nxt;
    child_r      <= child_nxt;
    out_index_r  <= out_index_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_has_r    <= out_has_nxt;
    out_end_r    <= out_end_nxt;
  end

endmodule

// File: sv/lz78c_checker.sv
`include "lz78_byte_compressor_defines.svh"

module lz78c_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lz78c_pkg::CODE_W-1:0] code_index,
  input logic [lz78c_pkg::SYM_W-1:0]  code_symbol,
  input logic                         has_symbol,
  input logic                         stream_end
);
  import lz78c_pkg::*;

  // a token stalled at the output holds its contents
  `LZ78C_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_index) && $stable(code_symbol) && $stable(has_symbol) && $stable(stream_end))

  // every token is either a pair or the trailing index, never both
  `LZ78C_ASSERT_NOW(a_token_kind, out_valid, has_symbol != stream_end)

  // the trailing token carries no byte
  `LZ78C_ASSERT_NOW(a_end_no_sym, out_valid && stream_end, code_symbol == '0)

  // output register is empty right after reset
  `LZ78C_ASSERT_RST(a_rst_out, !rst_n, !out_valid)

endmodule

bind lz78_byte_compressor lz78c_checker u_lz78c_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .code_index  (out_ch.code_index),
  .code_symbol (out_ch.code_symbol),
  .has_symbol  (out_ch.has_symbol),
  .stream_end  (out_ch.stream_end)
);

// File: bench/tb_lz78_byte_compressor.sv
module tb_lz78_byte_compressor;
  timeunit 1ns;
  timeprecision 1ps;

  import lz78c_pkg::*;

  localparam int N_PHASES      = 8;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int TIMEOUT_NS    = 5_000_000;

  typedef struct packed {
    logic [CODE_W-1:0] code_index;
    logic [SYM_W-1:0]  code_symbol;
    logic              has_symbol;
    logic              stream_end;
  } token_t;

  typedef enum int {ROW_ITEM, ROW_LIMIT} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               cmd;
    logic [SYM_W-1:0]   data;
    logic [LIMIT_W-1:0] lim;
    bit                 given;  // expected token written out by hand
    token_t             tok;
  } plan_row_t;

  localparam token_t TOK_END = '{12'd0, 8'h00, 1'b0, 1'b1};
  localparam token_t TOK_NONE = '0;

  localparam int PLAN_LEN = 27;
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_ITEM,  CMD_FINISH, 8'h00, '0, 1'b1, TOK_END},   // empty stream
    '{ROW_ITEM,  CMD_DATA,   8'h00, '0, 1'b1, '{12'd0, 8'h00, 1'b1, 1'b0}},
    '{ROW_ITEM,  CMD_DATA,   8'hFF, '0, 1'b1, '{12'd0, 8'hFF, 1'b1, 1'b0}},
    '{ROW_ITEM,  CMD_DATA,   8'h00, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'hFF, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'h00, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'hFF, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'h5A, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'hFF, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_FINISH, 8'hA5, '0, 1'b0, TOK_NONE},  // byte ignored on finish
    '{ROW_ITEM,  CMD_FINISH, 8'h00, '0, 1'b1, TOK_END},
    '{ROW_LIMIT, CMD_DATA,   8'h00, 13'd2, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'h07, '0, 1'b1, '{12'd0, 8'h07, 1'b1, 1'b0}},
    '{ROW_ITEM,  CMD_DATA,   8'h07, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'h07, '0, 1'b0, TOK_NONE},  // full: no insert
    '{ROW_ITEM,  CMD_DATA,   8'h07, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'h09, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'h09, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'h09, '0, 1'b0, TOK_NONE},
    '{ROW_LIMIT, CMD_DATA,   8'h00, 13'd0, 1'b0, TOK_NONE},  // lowered mid-stream
    '{ROW_ITEM,  CMD_DATA,   8'h07, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'h07, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_FINISH, 8'h00, '0, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_DATA,   8'h07, '0, 1'b1, '{12'd0, 8'h07, 1'b1, 1'b0}},
    '{ROW_ITEM,  CMD_DATA,   8'h07, '0, 1'b1, '{12'd0, 8'h07, 1'b1, 1'b0}},
    '{ROW_LIMIT, CMD_DATA,   8'h00, 13'd8191, 1'b0, TOK_NONE},
    '{ROW_ITEM,  CMD_FINISH, 8'h00, '0, 1'b1, TOK_END}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  lz78c_in_if  in_bus ();
  lz78c_out_if out_bus ();

  lz78_byte_compressor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // dictionary mirror
  logic [CODE_W-1:0]  dict_parent [CODE_SPACE];
  logic [SYM_W-1:0]   dict_symbol [CODE_SPACE];
  int                 free_code = 1;
  logic [CODE_W-1:0]  match_node = '0;
  logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;

  token_t pending_tokens [$];

  int fail_count     = 0;
  int items_sent     = 0;
  int finishes_sent  = 0;
  int tokens_checked = 0;
  int peak_codes     = 1;
  bit src_gaps_on    = 1'b1;
  bit sink_gaps_on   = 1'b1;
  bit long_hold_req  = 1'b0;

  // One compressor step; returns 1 when a token comes out.
  function automatic bit lz78_encode_step(input logic cmd, input logic [SYM_W-1:0] b,
                                          output token_t tok);
    int cap;
    tok = '0;
    if (cmd == CMD_FINISH) begin
      tok.code_index = match_node;
      tok.stream_end = 1'b1;
      free_code  = 1;
      match_node = '0;
      return 1'b1;
    end
    for (int c = 1; c < free_code; c++) begin
      if (dict_parent[c] == match_node && dict_symbol[c] == b) begin
        match_node = CODE_W'(c);
        return 1'b0;
      end
    end
    tok.code_index  = match_node;
    tok.code_symbol = b;
    tok.has_symbol  = 1'b1;
    cap = (DICT_SIZE < CODE_SPACE) ? DICT_SIZE : CODE_SPACE;
    if (int'(limit_reg) < cap) cap = int'(limit_reg);
    if (free_code < cap) begin
      dict_parent[free_code] = match_node;
      dict_symbol[free_code] = b;
      free_code++;
      if (free_code > peak_codes) peak_codes = free_code;
    end
    match_node = '0;
    return 1'b1;
  endfunction

  task automatic send_item(input logic cmd, input logic [SYM_W-1:0] b, input bit given,
                           input token_t given_tok);
    token_t tok;
    bit     emits;
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.cmd       <= cmd;
    in_bus.data_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    emits = lz78_encode_step(cmd, b, tok);
    if (given) begin
      emits = 1'b1;
      tok   = given_tok;
    end
    if (emits) pending_tokens.insert(pending_tokens.size(), tok);
    items_sent++;
    if (cmd == CMD_FINISH) finishes_sent++;
  endtask

  // Register write only with the block drained; a matched byte leaves no token
  // behind, so give it time to finish its probes as well.
  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    in_bus.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = v;
  endtask

  task automatic check_token();
    token_t want;
    if (pending_tokens.size() == 0) begin
      $error("unexpected token: code_index %0d code_symbol %0h has_symbol %0b stream_end %0b",
             out_bus.code_index, out_bus.code_symbol, out_bus.has_symbol, out_bus.stream_end);
      fail_count++;
      return;
    end
    want = pending_tokens.pop_front();
    if (out_bus.code_index !== want.code_index) begin
      $error("code_index: expected %0d, got %0d", want.code_index, out_bus.code_index);
      fail_count++;
    end
    if (out_bus.code_symbol !== want.code_symbol) begin
      $error("code_symbol: expected %0h, got %0h", want.code_symbol, out_bus.code_symbol);
      fail_count++;
    end
    if (out_bus.has_symbol !== want.has_symbol) begin
      $error("has_symbol: expected %0b, got %0b", want.has_symbol, out_bus.has_symbol);
      fail_count++;
    end
    if (out_bus.stream_end !== want.stream_end) begin
      $error("stream_end: expected %0b, got %0b", want.stream_end, out_bus.stream_end);
      fail_count++;
    end
    tokens_checked++;
  endtask

  // token sink with random stalls and one long hold-off
  initial begin : token_sink
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) check_token();
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end else if (hold_left == 0 && sink_gaps_on && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(1, 16);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] lim;
    logic [SYM_W-1:0]   alpha_base;
    int                 alpha_span;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.cmd       <= CMD_DATA;
    in_bus.data_byte <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LIMIT) begin
        set_limit(plan[i].lim);
      end else begin
        send_item(plan[i].cmd, plan[i].data, plan[i].given, plan[i].tok);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: lim = 13'd4096;
        1: lim = 13'd16;
        2: lim = 13'd2;
        3: lim = 13'd1;
        4: lim = 13'd8191;
        5: lim = LIMIT_W'($urandom_range(3, 64));
        6: lim = LIMIT_W'($urandom_range(0, 8191));
        default: lim = 13'd4096;
      endcase
      // half the time the limit changes in the middle of a stream
      if ($urandom_range(0, 1) == 0) send_item(CMD_FINISH, SYM_W'($urandom), 1'b0, TOK_NONE);
      set_limit(lim);
      src_gaps_on  = (ph != 3) && (ph != N_PHASES - 1);
      sink_gaps_on = src_gaps_on;
      if (ph == 1) long_hold_req = 1'b1;
      alpha_base = SYM_W'($urandom);
      case ($urandom_range(0, 4))
        0: alpha_span = 1;
        1: alpha_span = 2;
        2: alpha_span = 3;
        3: alpha_span = 4;
        default: alpha_span = 16;
      endcase
      // mostly a narrow alphabet so phrases grow deep; some noise bytes
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 79) == 0) begin
          send_item(CMD_FINISH, SYM_W'($urandom), 1'b0, TOK_NONE);
        end else if ($urandom_range(0, 9) < 2) begin
          send_item(CMD_DATA, SYM_W'($urandom), 1'b0, TOK_NONE);
        end else begin
          send_item(CMD_DATA, SYM_W'(alpha_base + $urandom_range(0, alpha_span - 1)),
                    1'b0, TOK_NONE);
        end
      end
    end

    in_bus.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d stream finishes), checked %0d tokens,",
             items_sent, finishes_sent, tokens_checked);
    $display("dictionary grew to %0d codes; limits 0, 1, 2, 16, 4096, 8191 and random ones, %s",
             peak_codes, "with one long output stall.");
    if (fail_count == 0) begin
      $display("tb_lz78_byte_compressor: PASS");
    end else begin
      $display("tb_lz78_byte_compressor: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d tokens still expected.", pending_tokens.size());
    $display("tb_lz78_byte_compressor: FAIL");
    $finish;
  end

endmodule
